### hw/rtl/mse_pkg.sv
// Package for the Morse symbol encoder: types, symbol codes, character index and code ROM.
`timescale 1ns / 1ps
package mse_pkg;

	// Morse elements on the output
	typedef enum logic [1:0] {
		SYM_DOT  = 2'd0,
		SYM_DASH = 2'd1,
		SYM_SEP  = 2'd2
	} symbol_t;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned ADDR_W = IDX_W + 1;
	localparam int unsigned PAT_W  = 7;

	// One ROM word: dot/dash pattern (first element at MSB), element count, separator count
	typedef struct packed {
		logic [2:0]       n_elem;
		logic [PAT_W-1:0] pat;
		logic [1:0]       n_sep;
	} code_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} char_idx_t;

	// Lookup stage to serializer
	typedef struct packed {
		logic  valid;
		logic  hit;
		code_t code;
	} s1_t;

	// Table slots: letters 0..25, digits 26..35, then space, period, Polish letters
	localparam logic [IDX_W-1:0] IDX_DIGIT0   = 6'd26;
	localparam logic [IDX_W-1:0] IDX_SPACE    = 6'd36;
	localparam logic [IDX_W-1:0] IDX_PERIOD   = 6'd37;
	localparam logic [IDX_W-1:0] IDX_A_OGONEK = 6'd38;
	localparam logic [IDX_W-1:0] IDX_C_ACUTE  = 6'd39;
	localparam logic [IDX_W-1:0] IDX_E_OGONEK = 6'd40;
	localparam logic [IDX_W-1:0] IDX_L_STROKE = 6'd41;
	localparam logic [IDX_W-1:0] IDX_N_ACUTE  = 6'd42;
	localparam logic [IDX_W-1:0] IDX_O_ACUTE  = 6'd43;
	localparam logic [IDX_W-1:0] IDX_S_ACUTE  = 6'd44;
	localparam logic [IDX_W-1:0] IDX_Z_ACUTE  = 6'd45;
	localparam logic [IDX_W-1:0] IDX_Z_DOT    = 6'd46;

	// Case fold and slot lookup in one step; upper and lower case share a slot
	function automatic char_idx_t char_index(input logic [15:0] c);
		char_idx_t r;
		r.hit = 1'b1;
		r.idx = '0;
		case (c) inside
			[16'd65:16'd90]:   r.idx = IDX_W'(c - 16'd65);
			[16'd97:16'd122]:  r.idx = IDX_W'(c - 16'd97);
			[16'd48:16'd57]:   r.idx = IDX_W'(c - 16'd48) + IDX_DIGIT0;
			16'd32:            r.idx = IDX_SPACE;
			16'd46:            r.idx = IDX_PERIOD;
			16'd260, 16'd261:  r.idx = IDX_A_OGONEK;
			16'd262, 16'd263:  r.idx = IDX_C_ACUTE;
			16'd280, 16'd281:  r.idx = IDX_E_OGONEK;
			16'd321, 16'd322:  r.idx = IDX_L_STROKE;
			16'd323, 16'd324:  r.idx = IDX_N_ACUTE;
			16'd211, 16'd243:  r.idx = IDX_O_ACUTE;
			16'd346, 16'd347:  r.idx = IDX_S_ACUTE;
			16'd377, 16'd378:  r.idx = IDX_Z_ACUTE;
			16'd379, 16'd380:  r.idx = IDX_Z_DOT;
			default:           r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// Pattern given right-aligned in n bits (1 = dash), stored left-aligned
	function automatic code_t mc(input logic [2:0] n, input logic [PAT_W-1:0] pat_r,
			input logic [1:0] s);
		code_t r;
		r.n_elem = n;
		r.pat    = pat_r << (3'd7 - n);
		r.n_sep  = s;
		return r;
	endfunction

	// Code ROM contents, address {variant, slot}
	function automatic code_t rom_word(input logic [ADDR_W-1:0] addr);
		code_t            r;
		logic [IDX_W-1:0] i;
		i = addr[IDX_W-1:0];
		// base table: Polish letters fall back to their base letter
		if (!addr[ADDR_W-1]) begin
			case (i)
				IDX_A_OGONEK: i = 6'd0;
				IDX_C_ACUTE:  i = 6'd2;
				IDX_E_OGONEK: i = 6'd4;
				IDX_L_STROKE: i = 6'd11;
				IDX_N_ACUTE:  i = 6'd13;
				IDX_O_ACUTE:  i = 6'd14;
				IDX_S_ACUTE:  i = 6'd18;
				IDX_Z_ACUTE:  i = 6'd25;
				IDX_Z_DOT:    i = 6'd25;
				default:      i = addr[IDX_W-1:0];
			endcase
		end
		case (i)
			6'd0:  r = mc(3'd2, 7'b01, 2'd1);
			6'd1:  r = mc(3'd4, 7'b1000, 2'd1);
			6'd2:  r = mc(3'd4, 7'b1010, 2'd1);
			6'd3:  r = mc(3'd3, 7'b100, 2'd1);
			6'd4:  r = mc(3'd1, 7'b0, 2'd1);
			6'd5:  r = mc(3'd4, 7'b0010, 2'd1);
			6'd6:  r = mc(3'd3, 7'b110, 2'd1);
			6'd7:  r = mc(3'd4, 7'b0000, 2'd1);
			6'd8:  r = mc(3'd2, 7'b00, 2'd1);
			6'd9:  r = mc(3'd4, 7'b0111, 2'd1);
			6'd10: r = mc(3'd3, 7'b101, 2'd1);
			6'd11: r = mc(3'd4, 7'b0100, 2'd1);
			6'd12: r = mc(3'd2, 7'b11, 2'd1);
			6'd13: r = mc(3'd2, 7'b10, 2'd1);
			6'd14: r = mc(3'd3, 7'b111, 2'd1);
			6'd15: r = mc(3'd4, 7'b0110, 2'd1);
			6'd16: r = mc(3'd4, 7'b1101, 2'd1);
			6'd17: r = mc(3'd3, 7'b010, 2'd1);
			6'd18: r = mc(3'd3, 7'b000, 2'd1);
			6'd19: r = mc(3'd1, 7'b1, 2'd1);
			6'd20: r = mc(3'd3, 7'b001, 2'd1);
			6'd21: r = mc(3'd4, 7'b0001, 2'd1);
			6'd22: r = mc(3'd3, 7'b011, 2'd1);
			6'd23: r = mc(3'd4, 7'b1001, 2'd1);
			6'd24: r = mc(3'd4, 7'b1011, 2'd1);
			6'd25: r = mc(3'd4, 7'b1100, 2'd1);
			6'd26: r = mc(3'd5, 7'b11111, 2'd1);
			6'd27: r = mc(3'd5, 7'b01111, 2'd1);
			6'd28: r = mc(3'd5, 7'b00111, 2'd1);
			6'd29: r = mc(3'd5, 7'b00011, 2'd1);
			6'd30: r = mc(3'd5, 7'b00001, 2'd1);
			6'd31: r = mc(3'd5, 7'b00000, 2'd1);
			6'd32: r = mc(3'd5, 7'b10000, 2'd1);
			6'd33: r = mc(3'd5, 7'b11000, 2'd1);
			6'd34: r = mc(3'd5, 7'b11100, 2'd1);
			6'd35: r = mc(3'd5, 7'b11110, 2'd1);
			IDX_SPACE:    r = mc(3'd0, 7'b0, 2'd1);
			IDX_PERIOD:   r = mc(3'd0, 7'b0, 2'd2);
			IDX_A_OGONEK: r = mc(3'd4, 7'b0101, 2'd1);
			IDX_C_ACUTE:  r = mc(3'd5, 7'b10100, 2'd1);
			IDX_E_OGONEK: r = mc(3'd5, 7'b00100, 2'd1);
			IDX_L_STROKE: r = mc(3'd5, 7'b01001, 2'd1);
			IDX_N_ACUTE:  r = mc(3'd5, 7'b11011, 2'd1);
			IDX_O_ACUTE:  r = mc(3'd4, 7'b1110, 2'd1);
			IDX_S_ACUTE:  r = mc(3'd7, 7'b0001000, 2'd1);
			IDX_Z_ACUTE:  r = mc(3'd5, 7'b11001, 2'd1);
			IDX_Z_DOT:    r = mc(3'd6, 7'b110010, 2'd1);
			default:      r = mc(3'd0, 7'b0, 2'd1);
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/mse_lookup.sv
// Input stage of the Morse symbol encoder: character slot lookup and synchronous code ROM read.
`timescale 1ns / 1ps
module mse_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       char_code,
	input  logic              variant,
	input  logic              load_ok,
	output mse_pkg::s1_t      s1
);

	mse_pkg::char_idx_t ci;
	logic               valid_s1;
	logic               hit_s1;
	mse_pkg::code_t     code_s1;

	assign ci = mse_pkg::char_index(char_code);

	// a miss leaves the stage at once; a hit waits for the serializer
	assign in_stall = valid_s1 && hit_s1 && !load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// ROM read, registered
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			hit_s1  <= ci.hit;
			code_s1 <= mse_pkg::rom_word({variant, ci.idx});
		end
	end

	assign s1.valid = valid_s1;
	assign s1.hit   = hit_s1;
	assign s1.code  = code_s1;

endmodule

### hw/rtl/mse_serializer.sv
// Output stage of the Morse symbol encoder: expands one code word into single symbols.
`timescale 1ns / 1ps
module mse_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  mse_pkg::s1_t      s1,
	output logic              load_ok,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        symbol,
	output logic              last
);

	logic                      valid_q;
	logic [2:0]                elem_cnt_q;
	logic [mse_pkg::PAT_W-1:0] pat_q;
	logic [1:0]                sep_cnt_q;
	logic                      fire;
	logic                      load;

	assign out_valid = valid_q;
	assign last      = (elem_cnt_q == 3'd0) && (sep_cnt_q == 2'd1);
	assign symbol    = (elem_cnt_q != 3'd0)
		? (pat_q[mse_pkg::PAT_W-1] ? mse_pkg::SYM_DASH : mse_pkg::SYM_DOT)
		: mse_pkg::SYM_SEP;

	assign fire    = valid_q && !out_stall;
	assign load_ok = !valid_q || (fire && last);
	assign load    = load_ok && s1.valid && s1.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (fire && last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			elem_cnt_q <= s1.code.n_elem;
			pat_q      <= s1.code.pat;
			sep_cnt_q  <= s1.code.n_sep;
		end else if (fire) begin
			if (elem_cnt_q != 3'd0) begin
				elem_cnt_q <= elem_cnt_q - 3'd1;
				pat_q      <= pat_q << 1;
			end else begin
				sep_cnt_q  <= sep_cnt_q - 2'd1;
			end
		end
	end

	// an active word always has a separator left to send
	a_sep_pending: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (sep_cnt_q != 2'd0))
		else $error("serializer active with no separator pending");

	// no character runs past eight symbols
	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (({1'b0, elem_cnt_q} + {2'b0, sep_cnt_q}) <= 4'd8))
		else $error("serializer holds more than eight symbols");

	// after the final symbol goes out with nothing to load, the output goes idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last && !(s1.valid && s1.hit)) |=> !out_valid)
		else $error("output valid held after last symbol");

	// a non-final symbol leaves the output valid
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !last) |=> out_valid)
		else $error("output dropped in the middle of a character");

endmodule

### hw/rtl/morse_symbol_encoder_top.sv
// Top level of the Morse symbol encoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall carries char_code, one UTF-16 code unit per
//   transaction. Output channel out_valid/out_stall carries symbol (0 dot,
//   1 dash, 2 separator) and last, set on the final symbol of a character.
//   Config channel cfg_valid/cfg_ready writes code_variant (0 base codes for
//   Polish letters, 1 Polish extended codes); cfg_ready is always high. Write
//   it only while no character is in flight.
//   A character accepted on the input is registered in the lookup stage, then
//   loaded into the serializer, whose registers drive its first symbol.
//   A character has 1 to 8 symbols; the next character is looked up
//   meanwhile, so symbols stream with no gap. Unknown characters produce
//   no output and do not wait for the serializer in the lookup stage. The
//   single output channel, one symbol per cycle when not stalled, sets
//   the rate. A stall on the output holds the current symbol; once the lookup
//   register is full, in_stall rises. Reset clears both stages and sets the
//   stored code_variant to 0.
module morse_symbol_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  symbol,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        code_variant
);

	logic         variant_q;
	logic         load_ok;
	mse_pkg::s1_t s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			variant_q <= code_variant;
		end
	end

	mse_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.variant   (variant_q),
		.load_ok   (load_ok),
		.s1        (s1)
	);

	mse_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last)
	);

endmodule
